[sv/mbrx_pkg.sv]
// shared types and constants for the modbus rtu frame receiver
// no dependencies; used by every module of the block
package mbrx_pkg;

    localparam int BUFFER_DEPTH = 128;
    localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);
    localparam int ECHO_LEN     = 8;
    localparam int ECHO_IDX_W   = $clog2(ECHO_LEN);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MIN_FRAME    = 4;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  ADDR_RESET    = 8'hEB;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5;
    localparam logic [7:0]  FN_WRITE_REG  = 8'h06;
    localparam logic [7:0]  BUZZ_REG_LO   = 8'd3;
    localparam logic [7:0]  BUZZ_REG_HI   = 8'd6;

    // configuration register indexes
    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    // input beat kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_ECHOED    = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_CRC_BAD   = 3'd2,
        ST_ADDR_BAD  = 3'd3,
        ST_FN_BAD    = 3'd4
    } status_t;

    // one judged frame, handed from front to back
    typedef struct packed {
        status_t                        status;
        logic [ECHO_LEN-1:0][7:0]       bytes;
        logic                           buzzer;
    } job_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SEND = 1'b1
    } back_state_t;

endpackage

[sv/modbus_rtu_frame_receiver_core.sv]
// top level of the modbus rtu frame receiver
// depends on mbrx_pkg, mbrx_front, mbrx_queue, mbrx_back
//
// Modbus RTU slave receive core. Each input beat is either a received byte
// (tuser 0) or one timer tick (tuser 1). Bytes are stored and reload the idle
// timer; when ticks run the timer to zero with bytes held, the frame is judged:
// fewer than four bytes, a CRC16 mismatch (check bytes high first), a wrong
// slave address or a function other than 6 each give one status beat; an
// accepted function 6 frame toggles the buzzer when register byte 3 lies in
// 3..6 and is echoed as eight transmit beats of buffer bytes 0..7. Input beats
// are taken one per cycle; a frame end needs a free slot in the two-entry job
// queue, so input stalls only when two judged frames still wait for output.
// The back end sends one result beat per cycle while the output is ready. The
// crc is folded in one byte per received byte, trailing by two so that the
// check bytes stay out. Past 128 bytes the byte count wraps and storage
// restarts at the first byte. There is no clearing pass after reset.
// Configuration (index 0 slave address, index 1 idle timeout in ticks) is
// written by the user only while the block is idle, which is not enforced.
module modbus_rtu_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] operation

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] tx_byte, [10:8] frame_status,
                                        // [18:11] function_code,
                                        // [26:19] register_low, [27] buzzer
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast    // last result of the run
);

    logic            q_full;
    logic            q_nonempty;
    logic            push;
    logic            pop;
    logic            in_beat;
    mbrx_pkg::job_t  push_job;
    mbrx_pkg::job_t  pop_job;
    logic [7:0]      tx_byte;
    logic [2:0]      frame_status;
    logic [7:0]      function_code;
    logic [7:0]      register_low;
    logic            buzzer;

    // stall input only while the queue cannot take another judged frame
    assign s_axis_tready = !q_full;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    mbrx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .beat      (in_beat),
        .operation (s_axis_tuser),
        .rx_byte   (s_axis_tdata),
        .push      (push),
        .push_job  (push_job)
    );

    mbrx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .nonempty (q_nonempty)
    );

    mbrx_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_avail     (q_nonempty),
        .job           (pop_job),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .kind          (m_axis_tuser),
        .tx_byte       (tx_byte),
        .frame_status  (frame_status),
        .function_code (function_code),
        .register_low  (register_low),
        .buzzer        (buzzer),
        .last          (m_axis_tlast)
    );

    assign m_axis_tdata = {4'h0, buzzer, register_low, function_code, frame_status, tx_byte};

    // a status result is always a run of one
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("status result without last");

    // echo beats carry the echoed status, status beats carry no byte
    a_kind_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (frame_status == mbrx_pkg::ST_ECHOED)) &&
                          (m_axis_tuser || tx_byte == 8'h00))
        else $error("kind and status disagree");

    // the front never hands a frame to a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("job queue overflow");

    // the back end only takes a job that is there
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_nonempty)
        else $error("job queue underflow");

endmodule

[sv/mbrx_front.sv]
// front end: byte capture, running crc, idle timer and frame judgment
// depends on mbrx_pkg
module mbrx_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                beat,
    input  logic                operation,
    input  logic [7:0]          rx_byte,
    output logic                push,
    output mbrx_pkg::job_t      push_job
);

    logic [7:0]                     slave_addr_reg;
    logic [15:0]                    timeout_reg;
    logic [mbrx_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [15:0]                    timer_reg, timer_next;
    logic [15:0]                    crc_reg, crc_next;
    logic [7:0]                     b1_reg, b1_next;
    logic [7:0]                     b2_reg, b2_next;
    logic                           buzzer_reg, buzzer_next;
    logic [mbrx_pkg::ECHO_LEN-1:0][7:0] shadow_reg, shadow_next;
    logic [mbrx_pkg::COUNT_W-1:0]   wr_idx;
    mbrx_pkg::status_t              status;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ mbrx_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // a full buffer wraps the count back to the start
    assign wr_idx = (count_reg == mbrx_pkg::COUNT_W'(mbrx_pkg::BUFFER_DEPTH))
                    ? '0 : count_reg;

    always_comb
    begin
        if (count_reg < mbrx_pkg::COUNT_W'(mbrx_pkg::MIN_FRAME))
            status = mbrx_pkg::ST_TOO_SHORT;
        else if (crc_reg != {b2_reg, b1_reg})
            status = mbrx_pkg::ST_CRC_BAD;
        else if (shadow_reg[0] != slave_addr_reg)
            status = mbrx_pkg::ST_ADDR_BAD;
        else if (shadow_reg[1] != mbrx_pkg::FN_WRITE_REG)
            status = mbrx_pkg::ST_FN_BAD;
        else
            status = mbrx_pkg::ST_ECHOED;
    end

    always_comb
    begin
        count_next  = count_reg;
        timer_next  = timer_reg;
        crc_next    = crc_reg;
        b1_next     = b1_reg;
        b2_next     = b2_reg;
        buzzer_next = buzzer_reg;
        shadow_next = shadow_reg;
        push        = 1'b0;
        if (beat && operation == mbrx_pkg::OP_BYTE)
        begin
            count_next = wr_idx + 1'b1;
            timer_next = timeout_reg;
            // crc trails the stream by two bytes: the last two are the check value
            if (wr_idx == '0)
                crc_next = mbrx_pkg::CRC_INIT;
            else if (wr_idx >= mbrx_pkg::COUNT_W'(2))
                crc_next = crc_byte(crc_reg, b2_reg);
            b2_next = b1_reg;
            b1_next = rx_byte;
            if (wr_idx < mbrx_pkg::COUNT_W'(mbrx_pkg::ECHO_LEN))
                shadow_next[wr_idx[mbrx_pkg::ECHO_IDX_W-1:0]] = rx_byte;
        end
        else if (beat && timer_reg != '0)
        begin
            timer_next = timer_reg - 1'b1;
            if (timer_reg == 16'd1 && count_reg != '0)
            begin
                push       = 1'b1;
                count_next = '0;
                if (status == mbrx_pkg::ST_ECHOED &&
                    shadow_reg[3] >= mbrx_pkg::BUZZ_REG_LO &&
                    shadow_reg[3] <= mbrx_pkg::BUZZ_REG_HI)
                    buzzer_next = ~buzzer_reg;
            end
        end
    end

    assign push_job.status = status;
    assign push_job.bytes  = shadow_reg;
    assign push_job.buzzer = buzzer_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= mbrx_pkg::ADDR_RESET;
            timeout_reg    <= mbrx_pkg::TIMEOUT_RESET;
            count_reg      <= '0;
            timer_reg      <= '0;
            crc_reg        <= mbrx_pkg::CRC_INIT;
            b1_reg         <= '0;
            b2_reg         <= '0;
            buzzer_reg     <= 1'b1;
            shadow_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == mbrx_pkg::CFG_SLAVE_ADDR)
                slave_addr_reg <= cfg_data[7:0];
            if (cfg_we && cfg_index == mbrx_pkg::CFG_TIMEOUT)
                timeout_reg <= cfg_data;
            count_reg  <= count_next;
            timer_reg  <= timer_next;
            crc_reg    <= crc_next;
            b1_reg     <= b1_next;
            b2_reg     <= b2_next;
            buzzer_reg <= buzzer_next;
            shadow_reg <= shadow_next;
        end
    end

endmodule

[sv/mbrx_queue.sv]
// short job queue between the judging front and the result back end
// depends on mbrx_pkg
module mbrx_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbrx_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output mbrx_pkg::job_t  pop_job,
    output logic            nonempty
);

    mbrx_pkg::job_t                 slot_reg [mbrx_pkg::QUEUE_DEPTH];
    logic [mbrx_pkg::QPTR_W-1:0]    wr_reg, wr_next;
    logic [mbrx_pkg::QPTR_W-1:0]    rd_reg, rd_next;
    logic [mbrx_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == mbrx_pkg::QCNT_W'(mbrx_pkg::QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign pop_job  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == mbrx_pkg::QPTR_W'(mbrx_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == mbrx_pkg::QPTR_W'(mbrx_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[sv/mbrx_back.sv]
// back end: turns a judged frame into one status beat or eight echo beats
// depends on mbrx_pkg
module mbrx_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_avail,
    input  mbrx_pkg::job_t  job,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            kind,
    output logic [7:0]      tx_byte,
    output logic [2:0]      frame_status,
    output logic [7:0]      function_code,
    output logic [7:0]      register_low,
    output logic            buzzer,
    output logic            last
);

    mbrx_pkg::back_state_t              state_reg, state_next;
    mbrx_pkg::job_t                     job_reg, job_next;
    logic [mbrx_pkg::ECHO_IDX_W-1:0]    idx_reg, idx_next;
    logic                               echo;
    logic                               done;

    assign echo          = (job_reg.status == mbrx_pkg::ST_ECHOED);
    assign out_valid     = (state_reg == mbrx_pkg::BK_SEND);
    assign kind          = echo;
    assign tx_byte       = echo ? job_reg.bytes[idx_reg] : 8'h00;
    assign frame_status  = job_reg.status;
    assign function_code = job_reg.bytes[1];
    assign register_low  = job_reg.bytes[3];
    assign buzzer        = job_reg.buzzer;
    assign last          = !echo || idx_reg == mbrx_pkg::ECHO_IDX_W'(mbrx_pkg::ECHO_LEN - 1);
    assign done          = out_valid && out_ready && last;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        case (state_reg)
            mbrx_pkg::BK_IDLE:
            begin
                if (job_avail)
                begin
                    pop        = 1'b1;
                    job_next   = job;
                    idx_next   = '0;
                    state_next = mbrx_pkg::BK_SEND;
                end
            end
            mbrx_pkg::BK_SEND:
            begin
                if (done)
                begin
                    // next frame follows straight on when one is waiting
                    if (job_avail)
                    begin
                        pop      = 1'b1;
                        job_next = job;
                        idx_next = '0;
                    end
                    else
                        state_next = mbrx_pkg::BK_IDLE;
                end
                else if (out_valid && out_ready)
                    idx_next = idx_reg + 1'b1;
            end
            default:
                state_next = mbrx_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mbrx_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[test/tb_top.sv]
// self-checking testbench for modbus_rtu_frame_receiver_core
// depends on mbrx_pkg and the core; mirrors receiver state to predict every result beat
// directed table first (reset values, extremes, each status), then random frames
module tb_top;

    // one expected result beat, fields in the order they leave the block
    typedef struct {
        logic               kind;
        logic [7:0]         tx;
        mbrx_pkg::status_t  status;
        logic [7:0]         fn_code;
        logic [7:0]         reg_lo;
        logic               buzz;
        logic               eor;
    } beat_t;

    // what one row of the directed table does
    typedef enum {
        DO_BYTE,
        DO_TICK,
        DO_CHECK,
        DO_BAD_CHECK,
        DO_NOISE,
        DO_SET_ADDR,
        DO_SET_TIMEOUT
    } step_kind_t;

    typedef struct {
        step_kind_t         kind;
        logic [15:0]        val;
        int                 rep;
        bit                 typed;
        mbrx_pkg::status_t  st;
        logic [7:0]         fn_code;
        logic [7:0]         reg_lo;
        logic               buzz;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0;   // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [7:0] tx_byte, [10:8] frame_status,
                                        // [18:11] function_code, [26:19] register_low,
                                        // [27] buzzer
    logic        m_axis_tuser;          // [0] kind
    logic        m_axis_tlast;

    // receiver mirror: buffer, count, idle timer, buzzer and both registers
    logic [7:0]  rx_mem [mbrx_pkg::BUFFER_DEPTH];
    int          rx_count;
    logic [15:0] idle_left;
    logic        buzz_state;
    logic [7:0]  cur_addr;
    logic [15:0] cur_timeout;

    beat_t       made_beats[$];     // results caused by the latest input beat
    beat_t       awaited_beats[$];  // results still owed by the block
    beat_t       typed_beat;        // hand-written status from the directed table
    bit          typed_armed;

    int          errors;
    int          live_items;        // input beats that touched the receiver state
    int          sent_items;
    int          frames_judged;
    int          beats_seen;
    int          burst_left;

    modbus_rtu_frame_receiver_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // modbus crc16 of the first len buffer bytes, reflected poly
    function automatic logic [15:0] crc_over(input int len);
        logic [15:0] c;
        c = mbrx_pkg::CRC_INIT;
        for (int i = 0; i < len && i < mbrx_pkg::BUFFER_DEPTH; i++)
        begin
            c ^= {8'h00, rx_mem[i]};
            repeat (8) c = c[0] ? ((c >> 1) ^ mbrx_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // status and echo beats always report buffer bytes 1 and 3, stale or not
    function automatic void note(input logic kind, input logic [7:0] tx,
                                 input mbrx_pkg::status_t st, input logic eor);
        made_beats.push_back('{kind, tx, st, rx_mem[1], rx_mem[3], buzz_state, eor});
    endfunction

    // order of checks: length, crc (high byte first), address, function
    function automatic void judge_frame();
        int          n;
        logic [15:0] calc;
        logic [15:0] got;
        n = rx_count;
        rx_count = 0;
        frames_judged++;
        if (n < mbrx_pkg::MIN_FRAME)
        begin
            note(1'b0, 8'h00, mbrx_pkg::ST_TOO_SHORT, 1'b1);
            return;
        end
        calc = crc_over(n - 2);
        got = {rx_mem[n-2], rx_mem[n-1]};
        if (calc != got)
            note(1'b0, 8'h00, mbrx_pkg::ST_CRC_BAD, 1'b1);
        else if (rx_mem[0] != cur_addr)
            note(1'b0, 8'h00, mbrx_pkg::ST_ADDR_BAD, 1'b1);
        else if (rx_mem[1] != mbrx_pkg::FN_WRITE_REG)
            note(1'b0, 8'h00, mbrx_pkg::ST_FN_BAD, 1'b1);
        else
        begin
            // buzzer flips before the echo so every echo beat carries the new level
            if (rx_mem[3] >= mbrx_pkg::BUZZ_REG_LO && rx_mem[3] <= mbrx_pkg::BUZZ_REG_HI)
                buzz_state = ~buzz_state;
            for (int k = 0; k < mbrx_pkg::ECHO_LEN; k++)
                note(1'b1, rx_mem[k], mbrx_pkg::ST_ECHOED, k == mbrx_pkg::ECHO_LEN - 1);
        end
    endfunction

    // apply one accepted input beat to the mirror
    function automatic void advance_receiver(input logic op, input logic [7:0] data);
        made_beats.delete();
        if (op == mbrx_pkg::OP_BYTE)
        begin
            // count wraps only when the next byte shows up
            if (rx_count >= mbrx_pkg::BUFFER_DEPTH)
                rx_count = 0;
            rx_mem[rx_count] = data;
            rx_count++;
            idle_left = cur_timeout;
            live_items++;
        end
        else if (idle_left != 0)
        begin
            live_items++;
            idle_left--;
            if (idle_left == 0 && rx_count > 0)
                judge_frame();
        end
    endfunction

    // drive one input beat, bursts of random length with random gaps
    task automatic send_item(input logic op, input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(20, 40);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 10);
                gap = $urandom_range(1, 6);
            end
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_items++;
        advance_receiver(op, data);
        if (made_beats.size() != 0)
        begin
            if (typed_armed)
            begin
                awaited_beats.push_back(typed_beat);
                typed_armed = 0;
            end
            else
                foreach (made_beats[k])
                    awaited_beats.push_back(made_beats[k]);
        end
    endtask

    // register writes only once all owed results are out and the pipe has drained
    task automatic write_reg(input logic idx, input logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == mbrx_pkg::CFG_SLAVE_ADDR)
            cur_addr = val[7:0];
        else
            cur_timeout = val;
    endtask

    // append the check bytes of everything buffered so far, high byte first
    task automatic send_check(input bit corrupt);
        logic [15:0] c;
        c = crc_over(rx_count);
        if (corrupt)
            c ^= 16'h0001 << $urandom_range(0, 15);
        send_item(mbrx_pkg::OP_BYTE, c[15:8]);
        send_item(mbrx_pkg::OP_BYTE, c[7:0]);
    endtask

    // mostly well-formed frames with random content, some runts and bad crcs
    task automatic send_frame();
        int         pick;
        int         body;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 3))
                send_item(mbrx_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        end
        else
        begin
            body = $urandom_range(2, 8);
            for (int i = 0; i < body; i++)
            begin
                b = 8'($urandom_range(0, 255));
                if (i == 0 && $urandom_range(0, 9) < 8)
                    b = cur_addr;
                else if (i == 1 && $urandom_range(0, 9) < 7)
                    b = mbrx_pkg::FN_WRITE_REG;
                else if (i == 3 && $urandom_range(0, 1) == 1)
                    b = 8'($urandom_range(0, 9));   // lands on the buzzer range often
                send_item(mbrx_pkg::OP_BYTE, b);
                // a pause shorter than the timeout must not end the frame
                if (cur_timeout > 1 && $urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, cur_timeout - 1))
                        send_item(mbrx_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            end
            send_check(pick < 22);
        end
        repeat (cur_timeout) send_item(mbrx_pkg::OP_TICK, 8'($urandom_range(0, 255)));
        // ticks with the timer stopped
        repeat ($urandom_range(0, 2))
            send_item(mbrx_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    function automatic step_t mk(input step_kind_t kind, input logic [15:0] val,
                                 input int rep = 1);
        return '{kind, val, rep, 1'b0, mbrx_pkg::ST_ECHOED, 8'h00, 8'h00, 1'b0};
    endfunction

    // row whose frame end yields a status that can be written down directly
    function automatic step_t mk_status(input step_kind_t kind, input int rep,
                                        input mbrx_pkg::status_t st,
                                        input logic [7:0] fn_code,
                                        input logic [7:0] reg_lo, input logic buzz);
        return '{kind, 16'h0000, rep, 1'b1, st, fn_code, reg_lo, buzz};
    endfunction

    function automatic void check_field(input string fld, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fld, want, got);
            errors++;
        end
    endfunction

    // result side: compare every accepted beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_seen++;
            if (awaited_beats.size() == 0)
            begin
                $error("result beat with nothing expected: tdata 0x%0h tuser %0b",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                want = awaited_beats.pop_front();
                check_field("kind", {7'b0, want.kind}, {7'b0, m_axis_tuser});
                check_field("tx_byte", want.tx, m_axis_tdata[7:0]);
                check_field("frame_status", {5'b0, want.status}, {5'b0, m_axis_tdata[10:8]});
                check_field("function_code", want.fn_code, m_axis_tdata[18:11]);
                check_field("register_low", want.reg_lo, m_axis_tdata[26:19]);
                check_field("buzzer", {7'b0, want.buzz}, {7'b0, m_axis_tdata[27]});
                check_field("last", {7'b0, want.eor}, {7'b0, m_axis_tlast});
            end
        end
    end

    // result side pacing: modes from always ready to mostly stalled
    initial
    begin : sink_pacing
        int mode;
        int span;
        int phase;
        phase = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 80);
            repeat (span)
            begin
                @(posedge clk);
                phase++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (phase % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        step_t      steps[$];
        step_t      s;
        int         goal;
        int         frames;
        logic [7:0] hi;
        logic [7:0] addr;

        foreach (rx_mem[i])
            rx_mem[i] = 8'h00;
        rx_count = 0;
        idle_left = 16'h0000;
        buzz_state = 1'b1;
        cur_addr = mbrx_pkg::ADDR_RESET;
        cur_timeout = mbrx_pkg::TIMEOUT_RESET;
        typed_armed = 0;
        errors = 0;
        live_items = 0;
        sent_items = 0;
        frames_judged = 0;
        beats_seen = 0;
        burst_left = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: tick with the timer stopped, then a runt under timeout 5
        steps.push_back(mk(DO_TICK, 16'h00FF));
        steps.push_back(mk(DO_BYTE, 16'h00EB));
        steps.push_back(mk(DO_BYTE, 16'h0006));
        steps.push_back(mk_status(DO_TICK, 5, mbrx_pkg::ST_TOO_SHORT, 8'h06, 8'h00, 1'b1));
        // lowest address and shortest timeout; one frame each for bad function, address, crc
        steps.push_back(mk(DO_SET_TIMEOUT, 16'h0001));
        steps.push_back(mk(DO_SET_ADDR, 16'h0000));
        steps.push_back(mk(DO_BYTE, 16'h0000));
        steps.push_back(mk(DO_BYTE, 16'h0003));
        steps.push_back(mk(DO_BYTE, 16'h0000));
        steps.push_back(mk(DO_BYTE, 16'h0007));
        steps.push_back(mk(DO_CHECK, 16'h0000));
        steps.push_back(mk_status(DO_TICK, 1, mbrx_pkg::ST_FN_BAD, 8'h03, 8'h07, 1'b1));
        steps.push_back(mk(DO_BYTE, 16'h0001));
        steps.push_back(mk(DO_BYTE, 16'h0006));
        steps.push_back(mk(DO_BYTE, 16'h0000));
        steps.push_back(mk(DO_BYTE, 16'h0009));
        steps.push_back(mk(DO_CHECK, 16'h0000));
        steps.push_back(mk_status(DO_TICK, 1, mbrx_pkg::ST_ADDR_BAD, 8'h06, 8'h09, 1'b1));
        steps.push_back(mk(DO_BYTE, 16'h0000));
        steps.push_back(mk(DO_BYTE, 16'h0006));
        steps.push_back(mk(DO_BYTE, 16'h0000));
        steps.push_back(mk(DO_BYTE, 16'h000A));
        steps.push_back(mk(DO_BAD_CHECK, 16'h0000));
        steps.push_back(mk_status(DO_TICK, 1, mbrx_pkg::ST_CRC_BAD, 8'h06, 8'h0A, 1'b1));
        // zero timeout holds the frame open, then the longest timeout, then
        // a short one loaded by the check bytes ends it as an echo
        steps.push_back(mk(DO_SET_ADDR, 16'h00FF));
        steps.push_back(mk(DO_SET_TIMEOUT, 16'h0000));
        steps.push_back(mk(DO_BYTE, 16'h00FF));
        steps.push_back(mk(DO_BYTE, 16'h0006));
        steps.push_back(mk(DO_TICK, 16'h005A, 2));
        steps.push_back(mk(DO_SET_TIMEOUT, 16'hFFFF));
        steps.push_back(mk(DO_BYTE, 16'h0000));
        steps.push_back(mk(DO_BYTE, 16'h0005));
        steps.push_back(mk(DO_TICK, 16'h00A5, 3));
        steps.push_back(mk(DO_SET_TIMEOUT, 16'h0002));
        steps.push_back(mk(DO_CHECK, 16'h0000));
        steps.push_back(mk(DO_TICK, 16'h0000, 2));
        // overflow: the count wraps past the buffer depth, the frame restarts at 0
        steps.push_back(mk(DO_SET_ADDR, {8'h00, mbrx_pkg::ADDR_RESET}));
        steps.push_back(mk(DO_NOISE, 16'h0000, mbrx_pkg::BUFFER_DEPTH + 3));
        steps.push_back(mk(DO_CHECK, 16'h0000));
        steps.push_back(mk(DO_TICK, 16'h0000, 2));

        foreach (steps[i])
        begin
            s = steps[i];
            if (s.typed)
            begin
                typed_beat = '{1'b0, 8'h00, s.st, s.fn_code, s.reg_lo, s.buzz, 1'b1};
                typed_armed = 1;
            end
            case (s.kind)
                DO_SET_ADDR:    write_reg(mbrx_pkg::CFG_SLAVE_ADDR, s.val);
                DO_SET_TIMEOUT: write_reg(mbrx_pkg::CFG_TIMEOUT, s.val);
                DO_CHECK:       send_check(1'b0);
                DO_BAD_CHECK:
                begin
                    hi = 8'(crc_over(rx_count) >> 8);
                    send_item(mbrx_pkg::OP_BYTE, hi ^ 8'h80);
                    send_item(mbrx_pkg::OP_BYTE, 8'h00);
                end
                DO_NOISE:
                    repeat (s.rep) send_item(mbrx_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
                DO_TICK:
                    repeat (s.rep) send_item(mbrx_pkg::OP_TICK, s.val[7:0]);
                default:
                    repeat (s.rep) send_item(mbrx_pkg::OP_BYTE, s.val[7:0]);
            endcase
            if (typed_armed)
            begin
                $error("step %0d: frame end with status %s never happened", i, s.st.name());
                errors++;
                typed_armed = 0;
            end
        end

        // random frames; the register settings move every few frames
        goal = live_items + 130;
        frames = 0;
        while (live_items < goal)
        begin
            if (frames % 5 == 4)
            begin
                case ($urandom_range(0, 3))
                    0: addr = 8'h00;
                    1: addr = 8'hFF;
                    2: addr = mbrx_pkg::ADDR_RESET;
                    default: addr = 8'($urandom_range(0, 255));
                endcase
                hi = 8'($urandom_range(0, 255));
                write_reg(mbrx_pkg::CFG_SLAVE_ADDR, {hi, addr});  // upper bits are don't-care
                write_reg(mbrx_pkg::CFG_TIMEOUT, 16'($urandom_range(1, 4)));
            end
            send_frame();
            frames++;
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d input beats, %0d frames judged, %0d result beats checked",
                 sent_items, frames_judged, beats_seen);
        $display("address 0x00/0xff/reset/random, timeout 0/1/2/65535/1..4, wrap past %0d",
                 mbrx_pkg::BUFFER_DEPTH);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
